// ===== rtl/gfge_pkg.sv =====
// ----------------------------------------------------------------------------
// gfge_pkg
// Shared types, constants and the exponential fraction table for the
// gaussian field gradient evaluator.
// ----------------------------------------------------------------------------
package gfge_pkg;

	localparam int EXP_DEPTH = 256;
	localparam int IDX_W     = $clog2(EXP_DEPTH);
	localparam int DIV_STAGES = 32;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [21:0] A_CAP     = 22'h200000;
	localparam logic [38:0] R2_CAP    = 39'h4000000000;
	localparam logic [31:0] POS_SAT   = 32'h7FFFFFFF;
	localparam logic [31:0] NEG_SAT   = 32'h80000000;

	typedef enum logic [1:0] {
		REG_CENTER_X      = 2'd0,
		REG_DOMAIN_HEIGHT = 2'd1,
		REG_INV_EPSILON   = 2'd2,
		REG_ALPHA4        = 2'd3
	} cfg_reg_t;

	typedef logic [30:0] exp_tab_t [EXP_DEPTH];

	// distance data that rides along the exponent stages
	typedef struct packed {
		logic [32:0] mag_x;
		logic [32:0] mag_y;
		logic        neg_x;
		logic        neg_y;
		logic        last;
	} fe_pass_t;

	typedef struct packed {
		logic        valid;
		logic [16:0] t;
		fe_pass_t    pass;
	} front_out_t;

	typedef struct packed {
		logic [33:0] denom;
		logic [31:0] grad_x;
		logic [31:0] grad_y;
		logic [16:0] t;
		logic        last;
	} div_side_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		div_side_t   side;
	} grad_out_t;

	// 2^(-k/depth) in Q1.30 from a series with terms up to the 15th power
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] y;
		logic [63:0] term;
		longint      sum;
		logic [63:0] res;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			y = (64'(k) * LN2_Q32) / 64'(EXP_DEPTH);
			term = 64'h1_0000_0000;
			sum = 64'sh1_0000_0000;
			for (int i = 1; i <= 15; i++) begin
				term = ((term * y) >> 32) / 64'(i);
				if (i % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			res = (64'(sum) + 64'd2) >> 2;
			tab[k] = res[30:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/gaussian_field_gradient_eval.sv =====
// ----------------------------------------------------------------------------
// gaussian_field_gradient_eval
// Gaussian field value, gradients and potentials for one grid node per item.
//
//  channel   signals                                   direction
//  node in   in_valid, in_stall, x_pos, y_pos,         into block
//            last_node
//  result    out_valid, out_stall, field_value,        out of block
//            grad_x, grad_y, potential_x, potential_y,
//            last_out
//  config    cfg_we, cfg_index, cfg_data               into block
//
// One item per cycle while no stalled result holds the pipeline; 8 exponent stages, 3 gradient
// stages, 32 divider stages and an output register. The divider sets the depth.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module gaussian_field_gradient_eval import gfge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	input  logic               last_node,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        field_value,
	output logic signed [31:0] grad_x,
	output logic signed [31:0] grad_y,
	output logic signed [31:0] potential_x,
	output logic signed [31:0] potential_y,
	output logic               last_out,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic signed [31:0] center_x_q;
	logic [30:0]        domain_height_q;
	logic [31:0]        inv_epsilon_q;
	logic [31:0]        alpha4_q;

	logic        en;
	front_out_t  fo;
	grad_out_t   go;
	logic        dv;
	logic [31:0] dq_x, dq_y;
	div_side_t   dside;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q      <= '0;
			domain_height_q <= '0;
			inv_epsilon_q   <= 32'd65536;
			alpha4_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:      center_x_q      <= cfg_data;
				REG_DOMAIN_HEIGHT: domain_height_q <= cfg_data[30:0];
				REG_INV_EPSILON:   inv_epsilon_q   <= cfg_data;
				REG_ALPHA4:        alpha4_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	gfge_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.last_node     (last_node),
		.center_x      (center_x_q),
		.domain_height (domain_height_q),
		.inv_epsilon   (inv_epsilon_q),
		.fo            (fo)
	);

	gfge_grad u_grad (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.fi          (fo),
		.inv_epsilon (inv_epsilon_q),
		.alpha4      (alpha4_q),
		.go          (go)
	);

	gfge_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.di     (go),
		.valid  (dv),
		.q_x    (dq_x),
		.q_y    (dq_y),
		.side   (dside)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			field_value <= dside.t;
			grad_x      <= dside.grad_x;
			grad_y      <= dside.grad_y;
			// quotient carries the gradient's sign back
			potential_x <= dside.grad_x[31] ? -dq_x : dq_x;
			potential_y <= dside.grad_y[31] ? -dq_y : dq_y;
			last_out    <= dside.last;
		end
	end

endmodule

// ===== rtl/gfge_front.sv =====
// ----------------------------------------------------------------------------
// gfge_front
// Offsets from the centre, squared radius, exponent scaling, base-2 range
// reduction, table lookup and final shift to the Gaussian value.
// ----------------------------------------------------------------------------
module gfge_front import gfge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	input  logic               last_node,
	input  logic signed [31:0] center_x,
	input  logic [30:0]        domain_height,
	input  logic [31:0]        inv_epsilon,
	output front_out_t         fo
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	fe_pass_t pass_s1, pass_s2, pass_s3, pass_s4, pass_s5, pass_s6, pass_s7, pass_s8;

	logic [48:0] sq_x_s2, sq_y_s2;
	logic [38:0] r2c_s3;
	logic [51:0] plo_s4;
	logic [50:0] phi_s4;
	logic [21:0] a_s5;
	logic [22:0] b_s6;
	logic [30:0] entry_s7;
	logic [4:0]  n_s7;
	logic        zero_s7;
	logic [16:0] t_s8;

	logic signed [32:0] dx, dy;
	logic [65:0] sqx, sqy;
	logic [49:0] r2;
	logic [70:0] prod;
	logic [52:0] bm;
	logic [28:0] idx_full;
	logic        wrap;
	logic [7:0]  n8;
	logic [IDX_W-1:0] idx;
	logic [5:0]  sh;
	logic [33:0] tsum, tsh;

	assign dx = {x_pos[31], x_pos} - {center_x[31], center_x};
	assign dy = {y_pos[31], y_pos} - {3'b000, domain_height[30:1]};

	assign sqx = 66'(pass_s1.mag_x) * 66'(pass_s1.mag_x);
	assign sqy = 66'(pass_s1.mag_y) * 66'(pass_s1.mag_y);

	assign r2 = {1'b0, sq_x_s2} + {1'b0, sq_y_s2};

	assign prod = 71'(plo_s4) + (71'(phi_s4) << 20);

	assign bm = 53'(a_s5) * 53'(LOG2E_Q30) + (53'd1 << 29);

	// fraction to table index, rounding up to the next power when it wraps
	assign idx_full = (29'(b_s6[15:0]) * 29'(EXP_DEPTH) + 29'd32768) >> 16;
	assign wrap     = (idx_full == 29'(EXP_DEPTH));
	assign n8       = {1'b0, b_s6[22:16]} + {7'd0, wrap};
	assign idx      = wrap ? '0 : idx_full[IDX_W-1:0];

	assign sh   = 6'(n_s7) + 6'd13;
	assign tsum = 34'(entry_s7) + (34'd1 << sh);
	assign tsh  = tsum >> (sh + 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s1.mag_x <= dx[32] ? 33'(-dx) : 33'(dx);
			pass_s1.mag_y <= dy[32] ? 33'(-dy) : 33'(dy);
			pass_s1.neg_x <= dx[32];
			pass_s1.neg_y <= dy[32];
			pass_s1.last  <= last_node;

			sq_x_s2 <= sqx[64:16];
			sq_y_s2 <= sqy[64:16];
			pass_s2 <= pass_s1;

			// anything this far out saturates the exponent for any nonzero scale
			r2c_s3  <= (|r2[49:38]) ? R2_CAP : r2[38:0];
			pass_s3 <= pass_s2;

			plo_s4  <= 52'(inv_epsilon) * 52'(r2c_s3[19:0]);
			phi_s4  <= 51'(inv_epsilon) * 51'(r2c_s3[38:20]);
			pass_s4 <= pass_s3;

			a_s5    <= (prod[70:16] > 55'(A_CAP)) ? A_CAP : prod[37:16];
			pass_s5 <= pass_s4;

			b_s6    <= bm[52:30];
			pass_s6 <= pass_s5;

			entry_s7 <= EXP_TAB[idx];
			n_s7     <= n8[4:0];
			zero_s7  <= (n8 >= 8'd20);
			pass_s7  <= pass_s6;

			t_s8    <= zero_s7 ? 17'd0 : tsh[16:0];
			pass_s8 <= pass_s7;
		end
	end

	assign fo.valid = v_s8;
	assign fo.t     = t_s8;
	assign fo.pass  = pass_s8;

endmodule

// ===== rtl/gfge_grad.sv =====
// ----------------------------------------------------------------------------
// gfge_grad
// Analytic gradients with saturation, and the potential denominator.
// ----------------------------------------------------------------------------
module gfge_grad import gfge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  front_out_t  fi,
	input  logic [31:0] inv_epsilon,
	input  logic [31:0] alpha4,
	output grad_out_t   go
);

	logic v_s1, v_s2, v_s3;
	logic [49:0] mxt_s1, myt_s1;
	logic [33:0] denom_s1, denom_s2, denom_s3;
	logic        neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2;
	logic [16:0] t_s1, t_s2, t_s3;
	logic        last_s1, last_s2, last_s3;
	logic [49:0] ghx_s2, ghy_s2;
	logic [63:0] glx_s2, gly_s2;
	logic [31:0] gx_s3, gy_s3, mx_s3, my_s3;

	logic [48:0] at;
	logic [63:0] satx, saty;

	assign at = 49'(alpha4) * 49'(fi.t);

	// floor(m*inv/2^31) from two partial products, then clamp; {grad, mag}
	function automatic logic [63:0] grad_sat(logic [49:0] gh, logic [63:0] gl, logic neg);
		logic [51:0] gs;
		logic [31:0] mag;
		gs = {1'b0, gh, 1'b0} + 52'(gl[63:31]);
		if (neg) begin
			mag = (gs > 52'(POS_SAT)) ? POS_SAT : gs[31:0];
			return {mag, mag};
		end else begin
			mag = (gs > 52'(NEG_SAT)) ? NEG_SAT : gs[31:0];
			return {32'(-mag), mag};
		end
	endfunction

	assign satx = grad_sat(ghx_s2, glx_s2, neg_x_s2);
	assign saty = grad_sat(ghy_s2, gly_s2, neg_y_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= fi.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxt_s1   <= 50'(fi.pass.mag_x) * 50'(fi.t);
			myt_s1   <= 50'(fi.pass.mag_y) * 50'(fi.t);
			denom_s1 <= 34'd65536 + 34'(at[48:16]);
			neg_x_s1 <= fi.pass.neg_x;
			neg_y_s1 <= fi.pass.neg_y;
			t_s1     <= fi.t;
			last_s1  <= fi.pass.last;

			ghx_s2   <= 50'(mxt_s1[49:32]) * 50'(inv_epsilon);
			glx_s2   <= 64'(mxt_s1[31:0]) * 64'(inv_epsilon);
			ghy_s2   <= 50'(myt_s1[49:32]) * 50'(inv_epsilon);
			gly_s2   <= 64'(myt_s1[31:0]) * 64'(inv_epsilon);
			denom_s2 <= denom_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			t_s2     <= t_s1;
			last_s2  <= last_s1;

			gx_s3    <= satx[63:32];
			mx_s3    <= satx[31:0];
			gy_s3    <= saty[63:32];
			my_s3    <= saty[31:0];
			denom_s3 <= denom_s2;
			t_s3     <= t_s2;
			last_s3  <= last_s2;
		end
	end

	assign go.valid       = v_s3;
	assign go.mag_x       = mx_s3;
	assign go.mag_y       = my_s3;
	assign go.side.denom  = denom_s3;
	assign go.side.grad_x = gx_s3;
	assign go.side.grad_y = gy_s3;
	assign go.side.t      = t_s3;
	assign go.side.last   = last_s3;

endmodule

// ===== rtl/gfge_div.sv =====
// ----------------------------------------------------------------------------
// gfge_div
// Pipelined restoring divider, one quotient bit per stage, for both
// gradient magnitudes scaled by 2^16 over the shared denominator.
// ----------------------------------------------------------------------------
module gfge_div import gfge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  grad_out_t   di,
	output logic        valid,
	output logic [31:0] q_x,
	output logic [31:0] q_y,
	output div_side_t   side
);

	logic [47:0] remx_s [DIV_STAGES];
	logic [47:0] remy_s [DIV_STAGES];
	logic [31:0] qx_s   [DIV_STAGES];
	logic [31:0] qy_s   [DIV_STAGES];
	div_side_t   side_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] v_s;

	genvar i;
	for (i = 0; i < DIV_STAGES; i++) begin : g_st
		localparam int K = DIV_STAGES - 1 - i;
		logic [47:0] rxi, ryi, rxo, ryo;
		logic [31:0] qxi, qyi, qxo, qyo;
		div_side_t   si;
		logic        vi;
		logic [65:0] dsh;
		logic        gex, gey;

		if (i == 0) begin : g_first
			assign rxi = {di.mag_x, 16'd0};
			assign ryi = {di.mag_y, 16'd0};
			assign qxi = '0;
			assign qyi = '0;
			assign si  = di.side;
			assign vi  = di.valid;
		end else begin : g_next
			assign rxi = remx_s[i-1];
			assign ryi = remy_s[i-1];
			assign qxi = qx_s[i-1];
			assign qyi = qy_s[i-1];
			assign si  = side_s[i-1];
			assign vi  = v_s[i-1];
		end

		assign dsh = {32'd0, si.denom} << K;
		assign gex = ({18'd0, rxi} >= dsh);
		assign gey = ({18'd0, ryi} >= dsh);

		always_comb begin
			rxo = gex ? (rxi - dsh[47:0]) : rxi;
			ryo = gey ? (ryi - dsh[47:0]) : ryi;
			qxo = qxi;
			qyo = qyi;
			qxo[K] = gex;
			qyo[K] = gey;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[i] <= rxo;
				remy_s[i] <= ryo;
				qx_s[i]   <= qxo;
				qy_s[i]   <= qyo;
				side_s[i] <= si;
			end
		end
	end

	assign valid = v_s[DIV_STAGES-1];
	assign q_x   = qx_s[DIV_STAGES-1];
	assign q_y   = qy_s[DIV_STAGES-1];
	assign side  = side_s[DIV_STAGES-1];

endmodule
